// File: rtl/ibt_pkg.sv
// Interval booking table: shared types, codes and default sizes.
// Used by every module of the block; no dependencies.
package ibt_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int IN_TIME_BITS  = 32;
	localparam int COUNT_BITS    = 7;
	localparam int COUNT_MAX     = 127;

	localparam logic [1:0] STATUS_BOOKED  = 2'd0;
	localparam logic [1:0] STATUS_OVERLAP = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;
	localparam logic [1:0] STATUS_INVALID = 2'd3;

	typedef struct packed {
		logic [IN_TIME_BITS-1:0] start_time;
		logic [IN_TIME_BITS-1:0] end_time;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] booked_count;
	} rsp_t;

	// Control flags that travel with a request down the cell chain.
	typedef struct packed {
		logic valid;
		logic invalid;
		logic clash;
		logic stored;
	} pkt_flags_t;

endpackage

// File: rtl/ibt_cell.sv
// One table cell: holds one booked interval and a request stage.
// Depends on ibt_pkg (pkt_flags_t).
module ibt_cell import ibt_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int CNT_BITS  = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  pkt_flags_t           in_flags,
	input  logic [TIME_BITS-1:0] in_start,
	input  logic [TIME_BITS-1:0] in_end,
	input  logic [CNT_BITS-1:0]  in_cnt,
	output pkt_flags_t           out_flags,
	output logic [TIME_BITS-1:0] out_start,
	output logic [TIME_BITS-1:0] out_end,
	output logic [CNT_BITS-1:0]  out_cnt
);

	logic                 slot_valid_q;
	logic [TIME_BITS-1:0] slot_start_q;
	logic [TIME_BITS-1:0] slot_end_q;
	pkt_flags_t           flags_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] end_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic       hit;
	logic       store;
	pkt_flags_t flags_nxt;

	// Valid cells always form a prefix, so the first empty cell a clean
	// request meets is the lowest free one.
	assign hit   = in_flags.valid && slot_valid_q &&
	               (slot_start_q < in_end) && (slot_end_q > in_start);
	assign store = in_flags.valid && !in_flags.invalid && !in_flags.clash &&
	               !in_flags.stored && !slot_valid_q;

	always_comb begin
		flags_nxt        = in_flags;
		flags_nxt.clash  = in_flags.clash | hit;
		flags_nxt.stored = in_flags.stored | store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
			flags_q      <= '0;
		end else if (advance) begin
			slot_valid_q <= slot_valid_q | store;
			flags_q      <= flags_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			start_q <= in_start;
			end_q   <= in_end;
			cnt_q   <= in_cnt + CNT_BITS'(slot_valid_q | store);
			if (store) begin
				slot_start_q <= in_start;
				slot_end_q   <= in_end;
			end
		end
	end

	assign out_flags = flags_q;
	assign out_start = start_q;
	assign out_end   = end_q;
	assign out_cnt   = cnt_q;

endmodule

// File: rtl/ibt_obuf.sv
// Two-entry output buffer (output register plus skid slot).
// Depends on ibt_pkg (rsp_t).
module ibt_obuf import ibt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t push_data,
	output logic has_room,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic pop;

	assign pop      = out_valid_q && rsp_ready;
	// push only arrives while the skid slot is empty
	assign has_room = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: rtl/interval_booking_table_core.sv
// Interval booking table. A request passes through every cell register in turn, the
// last cell feeding the output buffer, before its result shows on rsp. Throughput:
// one transaction per cycle while the output buffer has room; requests stream down
// the cell chain back to back. Reset (arst_n low) empties the table and the chain;
// there is no clearing pass, the table is ready right after reset.
// Depends on ibt_pkg, ibt_cell, ibt_obuf.
module interval_booking_table_core import ibt_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Count of held bookings, wide enough to reach CAPACITY.
	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	// Chain taps: index 0 is the incoming request, index i+1 leaves cell i.
	pkt_flags_t           flags [CAPACITY+1];
	logic [TIME_BITS-1:0] starts[CAPACITY+1];
	logic [TIME_BITS-1:0] ends  [CAPACITY+1];
	logic [CNT_BITS-1:0]  cnts  [CAPACITY+1];

	logic       advance;
	logic       push;
	logic       cnt_sat;
	rsp_t       tail_rsp;
	pkt_flags_t tail;

	// The whole chain moves as one shift register. It only halts when both
	// output slots hold results, so a waiting result never blocks intake
	// until the skid slot fills as well.
	assign req_ready = advance;

	// Fields are taken modulo 2^TIME_BITS (zero-extended when wider).
	assign starts[0] = TIME_BITS'(req.start_time);
	assign ends[0]   = TIME_BITS'(req.end_time);
	assign cnts[0]   = '0;

	always_comb begin
		flags[0]         = '0;
		flags[0].valid   = req_valid;
		// empty or reversed interval: checked first, never stored
		flags[0].invalid = (starts[0] >= ends[0]);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ibt_cell #(
			.TIME_BITS(TIME_BITS),
			.CNT_BITS (CNT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_flags (flags[i]),
			.in_start (starts[i]),
			.in_end   (ends[i]),
			.in_cnt   (cnts[i]),
			.out_flags(flags[i+1]),
			.out_start(starts[i+1]),
			.out_end  (ends[i+1]),
			.out_cnt  (cnts[i+1])
		);
	end

	// Result decode at the end of the chain; priority invalid > overlap > full.
	assign tail    = flags[CAPACITY];
	assign cnt_sat = (32'(cnts[CAPACITY]) > 32'(COUNT_MAX));

	always_comb begin
		if (tail.invalid) begin
			tail_rsp.status = STATUS_INVALID;
		end else if (tail.clash) begin
			tail_rsp.status = STATUS_OVERLAP;
		end else if (tail.stored) begin
			tail_rsp.status = STATUS_BOOKED;
		end else begin
			tail_rsp.status = STATUS_FULL;
		end
		tail_rsp.booked_count = cnt_sat ? COUNT_BITS'(COUNT_MAX)
		                                : COUNT_BITS'(cnts[CAPACITY]);
	end

	assign push = advance && tail.valid;

	ibt_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(tail_rsp),
		.has_room (advance),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// File: rtl/ibt_checker.sv
// Port-level checker for interval_booking_table_core, with its bind.
// Depends on ibt_pkg.
module ibt_checker import ibt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	localparam int FULL_CNT = (CAPACITY > COUNT_MAX) ? COUNT_MAX : CAPACITY;

	logic [COUNT_BITS-1:0] last_cnt_q;
	logic                  take;

	assign take = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (take) begin
			last_cnt_q <= rsp.booked_count;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("stalled result changed");

	a_book_adds_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_BOOKED &&
		32'(last_cnt_q) < 32'(COUNT_MAX)
		|-> 32'(rsp.booked_count) == 32'(last_cnt_q) + 32'd1)
		else $error("booking did not add exactly one interval");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_BOOKED |-> rsp.booked_count == last_cnt_q)
		else $error("rejected request changed the count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_FULL |-> 32'(rsp.booked_count) == FULL_CNT)
		else $error("full status with room left");

endmodule

bind interval_booking_table_core ibt_checker #(.CAPACITY(CAPACITY)) u_ibt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
